// ===== rtl/rsws_pkg.sv =====
`timescale 1ns / 1ps
// Package for the reservation station wakeup/select unit.
// Holds item layouts, operation codes and the cell control struct; no dependencies.
package rsws_pkg;

    // Default sizes
    localparam int ENTRIES_DEF   = 8;
    localparam int WORD_BITS_DEF = 32;

    // Fixed field widths
    localparam int FUNC_W = 2;
    localparam int CYC_W  = 32;
    localparam int OPC_W  = 8;
    localparam int SEQ_W  = 16;
    localparam int TAG_W  = 5;
    localparam int VAL_W  = 32;
    localparam int OCC_W  = 4;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_DISPATCH  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BROADCAST = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SELECT    = 2'd2;

    // Ready cycle of an entry with both operands still pending
    localparam logic [CYC_W-1:0] NO_CYCLE = '1;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CYC_W-1:0]  cycle;
        logic [OPC_W-1:0]  opcode;
        logic [SEQ_W-1:0]  seq_num;
        logic [TAG_W-1:0]  tag_in;
        logic              first_pending;
        logic [TAG_W-1:0]  first_tag;
        logic [VAL_W-1:0]  first_value;
        logic              second_pending;
        logic [TAG_W-1:0]  second_tag;
        logic [VAL_W-1:0]  second_value;
    } t_in_item;

    typedef struct packed {
        logic              accepted;
        logic              issued;
        logic [OPC_W-1:0]  out_opcode;
        logic [SEQ_W-1:0]  out_seq;
        logic [TAG_W-1:0]  out_dest;
        logic [VAL_W-1:0]  out_first;
        logic [VAL_W-1:0]  out_second;
        logic [OCC_W-1:0]  occupancy;
    } t_out_item;

    // Per-entry bookkeeping held in one cell (operand words kept apart)
    typedef struct packed {
        logic [OPC_W-1:0] opcode;
        logic [SEQ_W-1:0] seq;
        logic [TAG_W-1:0] dest;
        logic             first_wait;
        logic [TAG_W-1:0] first_tag;
        logic             second_wait;
        logic [TAG_W-1:0] second_tag;
        logic [CYC_W-1:0] ready_cycle;
    } t_meta;

    // Fields of the issued entry travelling down the chain
    typedef struct packed {
        logic [OPC_W-1:0] opcode;
        logic [SEQ_W-1:0] seq;
        logic [TAG_W-1:0] dest;
    } t_issue;

    // Per-cell control from the top level
    typedef struct packed {
        logic occupied;
        logic load;
        logic bcast;
        logic select;
    } t_cell_ctl;

endpackage

// ===== rtl/rsws_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the reservation station unit.
// Depends on rsws_pkg for the item layouts.
interface rsws_in_if;
    logic                 valid;
    logic                 ready;
    rsws_pkg::t_in_item   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rsws_out_if;
    logic                 valid;
    logic                 ready;
    rsws_pkg::t_out_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rsws_cell.sv =====
`timescale 1ns / 1ps
// One station entry: holds the entry, snoops broadcasts, joins the age-ordered
// select chain and takes its younger neighbor's entry on compaction. Uses rsws_pkg.
module rsws_cell #(
    parameter int WORD_BITS = rsws_pkg::WORD_BITS_DEF
) (
    input  logic                   i_clk,
    input  rsws_pkg::t_cell_ctl    i_ctl,
    input  rsws_pkg::t_in_item     i_item,
    // younger neighbor's entry, shifted in on compaction
    input  rsws_pkg::t_meta        i_young_meta,
    input  logic [WORD_BITS-1:0]   i_young_first,
    input  logic [WORD_BITS-1:0]   i_young_second,
    // select chain from the older neighbor
    input  logic                   i_found,
    input  rsws_pkg::t_issue       i_sel_meta,
    input  logic [WORD_BITS-1:0]   i_sel_first,
    input  logic [WORD_BITS-1:0]   i_sel_second,
    // this entry, to the older neighbor
    output rsws_pkg::t_meta        o_meta,
    output logic [WORD_BITS-1:0]   o_first,
    output logic [WORD_BITS-1:0]   o_second,
    // select chain to the younger neighbor
    output logic                   o_found,
    output rsws_pkg::t_issue       o_sel_meta,
    output logic [WORD_BITS-1:0]   o_sel_first,
    output logic [WORD_BITS-1:0]   o_sel_second
);

    rsws_pkg::t_meta        r_meta, n_meta;
    logic [WORD_BITS-1:0]   r_first, n_first;
    logic [WORD_BITS-1:0]   r_second, n_second;
    logic                   w_ready;
    logic                   w_issue;
    rsws_pkg::t_issue       w_mine;

    // Ready to issue: both operands present and woken before this cycle
    assign w_ready = i_ctl.select && i_ctl.occupied && !r_meta.first_wait
                     && !r_meta.second_wait && (r_meta.ready_cycle < i_item.cycle);
    assign w_issue = w_ready && !i_found;
    assign o_found = i_found || w_ready;

    // The first ready entry puts itself on the chain; all others pass it on unchanged
    always_comb begin
        w_mine        = '0;
        w_mine.opcode = r_meta.opcode;
        w_mine.seq    = r_meta.seq;
        w_mine.dest   = r_meta.dest;
    end
    assign o_sel_meta   = w_issue ? w_mine : i_sel_meta;
    assign o_sel_first  = w_issue ? r_first : i_sel_first;
    assign o_sel_second = w_issue ? r_second : i_sel_second;

    // Next entry: dispatch fill, compaction shift, or wakeup
    always_comb begin
        n_meta   = r_meta;
        n_first  = r_first;
        n_second = r_second;
        if (i_ctl.load) begin
            n_meta.opcode      = i_item.opcode;
            n_meta.seq         = i_item.seq_num;
            n_meta.dest        = i_item.tag_in;
            n_meta.first_wait  = i_item.first_pending;
            n_meta.first_tag   = i_item.first_tag;
            n_meta.second_wait = i_item.second_pending;
            n_meta.second_tag  = i_item.second_tag;
            n_first  = i_item.first_pending ? '0 : WORD_BITS'(i_item.first_value);
            n_second = i_item.second_pending ? '0 : WORD_BITS'(i_item.second_value);
            n_meta.ready_cycle = (i_item.first_pending && i_item.second_pending)
                                 ? rsws_pkg::NO_CYCLE : i_item.cycle;
        end else if (o_found) begin
            // issue at or below this place: close the gap
            n_meta   = i_young_meta;
            n_first  = i_young_first;
            n_second = i_young_second;
        end else if (i_ctl.bcast) begin
            if (r_meta.first_wait && r_meta.first_tag == i_item.tag_in) begin
                n_first            = WORD_BITS'(i_item.first_value);
                n_meta.first_wait  = 1'b0;
                n_meta.ready_cycle = i_item.cycle;
            end
            if (r_meta.second_wait && r_meta.second_tag == i_item.tag_in) begin
                n_second           = WORD_BITS'(i_item.first_value);
                n_meta.second_wait = 1'b0;
                n_meta.ready_cycle = i_item.cycle;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        r_meta   <= n_meta;
        r_first  <= n_first;
        r_second <= n_second;
    end

    assign o_meta   = r_meta;
    assign o_first  = r_first;
    assign o_second = r_second;

endmodule

// ===== rtl/reservation_station_wakeup_select_unit.sv =====
`timescale 1ns / 1ps
// Reservation station top level: entry count, cell chain and result register.
// Depends on rsws_pkg, rsws_in_if/rsws_out_if and rsws_cell.
//
// Usage:
//   i_in carries one operation per item: dispatch (append an entry),
//   broadcast (wake operands waiting on tag_in with first_value) or
//   select (issue the oldest entry whose operands were ready before
//   the given cycle, then compact the station). o_out returns exactly one
//   result item per input item, in order.
//   The result is registered and shows on o_out in the cycle after the
//   input item is accepted.
//   Throughput: one item per cycle unless o_out stalls; all work is done in the
//   accept cycle; the select search ripples through the ENTRIES cells of
//   the chain, oldest first, and sets the path length.
//   Reset (i_rst_n low, synchronous) empties the station and the result
//   register. No clearing pass is needed: cells are only read below the
//   entry count.
//   Stall: while a result waits on o_out with o_out.ready low, i_in.ready
//   is low and the result holds; as soon as it is taken a new item is
//   accepted in the same cycle.
module reservation_station_wakeup_select_unit #(
    parameter int ENTRIES   = rsws_pkg::ENTRIES_DEF,
    parameter int WORD_BITS = rsws_pkg::WORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rsws_in_if.sink           i_in,
    rsws_out_if.source        o_out
);

    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [CNT_W-1:0]       r_count, n_count;
    logic                   r_out_valid;
    rsws_pkg::t_out_item    r_out, n_out;

    logic                   w_in_ready;
    logic                   w_accept;
    logic                   w_is_disp, w_is_bcast, w_is_sel;
    logic                   w_full;
    logic                   w_disp_ok;

    rsws_pkg::t_meta        w_meta   [ENTRIES];
    logic [WORD_BITS-1:0]   w_first  [ENTRIES];
    logic [WORD_BITS-1:0]   w_second [ENTRIES];
    logic                   w_found      [ENTRIES+1];
    rsws_pkg::t_issue       w_sel_meta   [ENTRIES+1];
    logic [WORD_BITS-1:0]   w_sel_first  [ENTRIES+1];
    logic [WORD_BITS-1:0]   w_sel_second [ENTRIES+1];

    // Handshake: take an item whenever the result register is free or draining
    assign w_in_ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;

    // Operation decode
    assign w_is_disp  = w_accept && (i_in.data.func == rsws_pkg::FUNC_DISPATCH);
    assign w_is_bcast = w_accept && (i_in.data.func == rsws_pkg::FUNC_BROADCAST);
    assign w_is_sel   = w_accept && (i_in.data.func == rsws_pkg::FUNC_SELECT);
    assign w_full     = (r_count == CNT_W'(ENTRIES));
    assign w_disp_ok  = w_is_disp && !w_full;

    // Select chain enters at the oldest cell empty
    assign w_found[0]      = 1'b0;
    assign w_sel_meta[0]   = '0;
    assign w_sel_first[0]  = '0;
    assign w_sel_second[0] = '0;

    // Cell chain, position 0 oldest
    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        rsws_pkg::t_cell_ctl  w_ctl;
        rsws_pkg::t_meta      w_y_meta;
        logic [WORD_BITS-1:0] w_y_first;
        logic [WORD_BITS-1:0] w_y_second;

        always_comb begin
            w_ctl          = '0;
            w_ctl.occupied = (CNT_W'(k) < r_count);
            w_ctl.load     = w_disp_ok && (r_count == CNT_W'(k));
            w_ctl.bcast    = w_is_bcast;
            w_ctl.select   = w_is_sel;
        end

        if (k == ENTRIES - 1) begin : g_last
            // youngest place refills from itself; it falls out of the count
            assign w_y_meta   = w_meta[k];
            assign w_y_first  = w_first[k];
            assign w_y_second = w_second[k];
        end else begin : g_mid
            assign w_y_meta   = w_meta[k+1];
            assign w_y_first  = w_first[k+1];
            assign w_y_second = w_second[k+1];
        end

        rsws_cell #(
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_ctl          (w_ctl),
            .i_item         (i_in.data),
            .i_young_meta   (w_y_meta),
            .i_young_first  (w_y_first),
            .i_young_second (w_y_second),
            .i_found        (w_found[k]),
            .i_sel_meta     (w_sel_meta[k]),
            .i_sel_first    (w_sel_first[k]),
            .i_sel_second   (w_sel_second[k]),
            .o_meta         (w_meta[k]),
            .o_first        (w_first[k]),
            .o_second       (w_second[k]),
            .o_found        (w_found[k+1]),
            .o_sel_meta     (w_sel_meta[k+1]),
            .o_sel_first    (w_sel_first[k+1]),
            .o_sel_second   (w_sel_second[k+1])
        );
    end

    // Entry count
    always_comb begin
        n_count = r_count;
        if (w_disp_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_found[ENTRIES]) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Result item
    always_comb begin
        n_out            = '0;
        n_out.accepted   = !(w_is_disp && w_full);
        n_out.issued     = w_found[ENTRIES];
        n_out.out_opcode = w_sel_meta[ENTRIES].opcode;
        n_out.out_seq    = w_sel_meta[ENTRIES].seq;
        n_out.out_dest   = w_sel_meta[ENTRIES].dest;
        n_out.out_first  = rsws_pkg::VAL_W'(w_sel_first[ENTRIES]);
        n_out.out_second = rsws_pkg::VAL_W'(w_sel_second[ENTRIES]);
        n_out.occupancy  = rsws_pkg::OCC_W'(n_count);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

// ===== rtl/rsws_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the reservation station unit, bound to the top level.
// Depends on rsws_pkg and reservation_station_wakeup_select_unit.
module rsws_checker #(
    parameter int ENTRIES = rsws_pkg::ENTRIES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  rsws_pkg::t_out_item  i_out_data
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    // Each accepted item yields a result in the next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("accepted item gave no result");

    // A free output side never blocks the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

    // No issue means zero entry fields
    a_no_issue_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.issued |->
            i_out_data.out_opcode == '0 && i_out_data.out_seq == '0
            && i_out_data.out_dest == '0 && i_out_data.out_first == '0
            && i_out_data.out_second == '0)
        else $error("fields set without issue");

    // A refused dispatch only happens on a full station
    a_refuse_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.accepted |->
            !i_out_data.issued && i_out_data.occupancy == rsws_pkg::OCC_W'(ENTRIES))
        else $error("dispatch refused below capacity");

endmodule

bind reservation_station_wakeup_select_unit rsws_checker #(
    .ENTRIES (ENTRIES)
) u_rsws_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

// ===== test/reservation_station_wakeup_select_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for reservation_station_wakeup_select_unit: directed rows,
// then random items. Depends on rsws_pkg, rsws_in_if/rsws_out_if and the unit RTL;
// an internal predictor checks o_out.
module reservation_station_wakeup_select_unit_test;

    localparam int ENTRIES = rsws_pkg::ENTRIES_DEF;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 5;
    localparam int MAX_REPORTS = 10;
    localparam logic [rsws_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [4:0] WAKE_TAG = 5'd17;

    // One station entry as the predictor keeps it
    typedef struct {
        logic [rsws_pkg::OPC_W-1:0] opcode;
        logic [rsws_pkg::SEQ_W-1:0] seq;
        logic [rsws_pkg::TAG_W-1:0] dest;
        bit                         first_wait;
        logic [rsws_pkg::TAG_W-1:0] first_tag;
        logic [rsws_pkg::VAL_W-1:0] first_word;
        bit                         second_wait;
        logic [rsws_pkg::TAG_W-1:0] second_tag;
        logic [rsws_pkg::VAL_W-1:0] second_word;
        logic [rsws_pkg::CYC_W-1:0] ready_cycle;
    } t_rs_slot;

    // Directed row: item plus an optional hand-written outcome
    typedef struct {
        rsws_pkg::t_in_item  item;
        bit                  typed;
        rsws_pkg::t_out_item want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    rsws_in_if  in_ch();
    rsws_out_if out_ch();

    reservation_station_wakeup_select_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_rs_slot                   slots [ENTRIES];
    int                         held;
    rsws_pkg::t_out_item        pending_outcomes [$];
    t_dir_row                   dir_rows [$];
    logic [rsws_pkg::CYC_W-1:0] cur_cycle;
    int                         fail_count;
    int                         src_idle_pct;
    int                         snk_idle_pct;
    int                         quiet_cycles;

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Apply one item to the predicted station and return its outcome
    function automatic rsws_pkg::t_out_item station_step(rsws_pkg::t_in_item it);
        rsws_pkg::t_out_item res;
        int                  pick;
        res = '0;
        res.accepted = 1'b1;
        pick = -1;
        case (it.func)
            rsws_pkg::FUNC_DISPATCH: begin
                if (held >= ENTRIES) begin
                    res.accepted = 1'b0;
                end else begin
                    slots[held].opcode      = it.opcode;
                    slots[held].seq         = it.seq_num;
                    slots[held].dest        = it.tag_in;
                    slots[held].first_wait  = it.first_pending;
                    slots[held].first_tag   = it.first_tag;
                    slots[held].first_word  = it.first_pending ? '0 : it.first_value;
                    slots[held].second_wait = it.second_pending;
                    slots[held].second_tag  = it.second_tag;
                    slots[held].second_word = it.second_pending ? '0 : it.second_value;
                    slots[held].ready_cycle = (it.first_pending && it.second_pending)
                                              ? rsws_pkg::NO_CYCLE : it.cycle;
                    held++;
                end
            end
            rsws_pkg::FUNC_BROADCAST: begin
                // wakeup: every waiting operand with a matching tag takes the word
                for (int i = 0; i < held; i++) begin
                    if (slots[i].first_wait && slots[i].first_tag == it.tag_in) begin
                        slots[i].first_word  = it.first_value;
                        slots[i].first_wait  = 1'b0;
                        slots[i].ready_cycle = it.cycle;
                    end
                    if (slots[i].second_wait && slots[i].second_tag == it.tag_in) begin
                        slots[i].second_word = it.first_value;
                        slots[i].second_wait = 1'b0;
                        slots[i].ready_cycle = it.cycle;
                    end
                end
            end
            rsws_pkg::FUNC_SELECT: begin
                // oldest entry ready strictly before this cycle
                for (int i = 0; i < held; i++) begin
                    if (pick < 0 && !slots[i].first_wait && !slots[i].second_wait &&
                        slots[i].ready_cycle < it.cycle)
                        pick = i;
                end
                if (pick >= 0) begin
                    res.issued     = 1'b1;
                    res.out_opcode = slots[pick].opcode;
                    res.out_seq    = slots[pick].seq;
                    res.out_dest   = slots[pick].dest;
                    res.out_first  = slots[pick].first_word;
                    res.out_second = slots[pick].second_word;
                    for (int k = pick; k + 1 < held; k++)
                        slots[k] = slots[k + 1];
                    held--;
                end
            end
            default: ;
        endcase
        res.occupancy = rsws_pkg::OCC_W'(held);
        return res;
    endfunction

    function automatic rsws_pkg::t_in_item mk_dispatch(
        logic [rsws_pkg::CYC_W-1:0] cyc, logic [rsws_pkg::OPC_W-1:0] opc,
        logic [rsws_pkg::SEQ_W-1:0] seq, logic [rsws_pkg::TAG_W-1:0] dest,
        bit fp, logic [rsws_pkg::TAG_W-1:0] ft, logic [rsws_pkg::VAL_W-1:0] fv,
        bit sp, logic [rsws_pkg::TAG_W-1:0] st, logic [rsws_pkg::VAL_W-1:0] sv);
        rsws_pkg::t_in_item it;
        it = '0;
        it.func           = rsws_pkg::FUNC_DISPATCH;
        it.cycle          = cyc;
        it.opcode         = opc;
        it.seq_num        = seq;
        it.tag_in         = dest;
        it.first_pending  = fp;
        it.first_tag      = ft;
        it.first_value    = fv;
        it.second_pending = sp;
        it.second_tag     = st;
        it.second_value   = sv;
        return it;
    endfunction

    function automatic rsws_pkg::t_in_item mk_op(
        logic [rsws_pkg::FUNC_W-1:0] fn, logic [rsws_pkg::CYC_W-1:0] cyc,
        logic [rsws_pkg::TAG_W-1:0] tag, logic [rsws_pkg::VAL_W-1:0] word);
        rsws_pkg::t_in_item it;
        it = '0;
        it.func        = fn;
        it.cycle       = cyc;
        it.tag_in      = tag;
        it.first_value = word;
        return it;
    endfunction

    function automatic rsws_pkg::t_out_item mk_outcome(
        bit acc, bit iss, logic [rsws_pkg::OPC_W-1:0] opc,
        logic [rsws_pkg::SEQ_W-1:0] seq, logic [rsws_pkg::TAG_W-1:0] dest,
        logic [rsws_pkg::VAL_W-1:0] a, logic [rsws_pkg::VAL_W-1:0] b,
        logic [rsws_pkg::OCC_W-1:0] occ);
        rsws_pkg::t_out_item o;
        o.accepted   = acc;
        o.issued     = iss;
        o.out_opcode = opc;
        o.out_seq    = seq;
        o.out_dest   = dest;
        o.out_first  = a;
        o.out_second = b;
        o.occupancy  = occ;
        return o;
    endfunction

    function automatic void add_row(rsws_pkg::t_in_item it, bit typed,
                                    rsws_pkg::t_out_item want);
        t_dir_row r;
        r.item  = it;
        r.typed = typed;
        r.want  = want;
        dir_rows.push_back(r);
    endfunction

    // Directed rows: empty select, unused code, extremes, wakeup, compaction, full station
    function automatic void build_rows();
        rsws_pkg::t_out_item none;
        none = '0;
        add_row(mk_op(rsws_pkg::FUNC_SELECT, 32'd0, 5'd0, '0), 1,
                mk_outcome(1, 0, 0, 0, 0, 0, 0, 4'd0));
        add_row(mk_op(FUNC_UNUSED, 32'd0, 5'd31, '1), 1,
                mk_outcome(1, 0, 0, 0, 0, 0, 0, 4'd0));
        add_row(mk_dispatch(32'd0, 8'hFF, 16'hFFFF, 5'd31, 0, 5'd31, '1, 0, 5'd31, '1), 1,
                mk_outcome(1, 0, 0, 0, 0, 0, 0, 4'd1));
        // ready in cycle 0 is not before cycle 0
        add_row(mk_op(rsws_pkg::FUNC_SELECT, 32'd0, 5'd0, '0), 1,
                mk_outcome(1, 0, 0, 0, 0, 0, 0, 4'd1));
        add_row(mk_op(rsws_pkg::FUNC_SELECT, 32'd1, 5'd0, '0), 1,
                mk_outcome(1, 1, 8'hFF, 16'hFFFF, 5'd31, '1, '1, 4'd0));
        // both pending: supplied words ignored, ready cycle left unset
        add_row(mk_dispatch(32'd2, 8'h00, 16'h0000, 5'd0, 1, 5'd31, 32'hDEAD_BEEF,
                            1, 5'd0, 32'hCAFE_F00D), 0, none);
        add_row(mk_dispatch(32'd2, 8'h5A, 16'h1234, 5'd7, 1, 5'd5, 32'h0BAD_0BAD,
                            0, 5'd0, 32'h1234_5678), 0, none);
        add_row(mk_dispatch(32'd2, 8'hA5, 16'h8001, 5'd16, 0, 5'd0, '0, 0, 5'd0, '0), 0, none);
        add_row(mk_op(rsws_pkg::FUNC_SELECT, 32'd2, 5'd0, '0), 0, none);
        add_row(mk_op(rsws_pkg::FUNC_BROADCAST, 32'd3, 5'd31, 32'hAAAA_AAAA), 0, none);
        add_row(mk_op(rsws_pkg::FUNC_BROADCAST, 32'd3, 5'd0, 32'h5555_5555), 0, none);
        // younger entry issues first, then the woken oldest one
        add_row(mk_op(rsws_pkg::FUNC_SELECT, 32'd3, 5'd0, '0), 0, none);
        add_row(mk_op(rsws_pkg::FUNC_SELECT, 32'd4, 5'd0, '0), 0, none);
        add_row(mk_op(rsws_pkg::FUNC_BROADCAST, 32'd4, 5'd5, '1), 0, none);
        add_row(mk_op(rsws_pkg::FUNC_SELECT, 32'd4, 5'd0, '0), 0, none);
        for (int i = 0; i < ENTRIES - 1; i++)
            add_row(mk_dispatch(32'd5 + i, 8'(8'h10 + i), 16'(16'h7FF0 + i), 5'(i + 1),
                                1, WAKE_TAG, $urandom, i[0], WAKE_TAG, $urandom), 0, none);
        add_row(mk_dispatch(32'd9, 8'h33, 16'h3333, 5'd3, 0, 5'd0, '1, 0, 5'd0, '1), 1,
                mk_outcome(0, 0, 0, 0, 0, 0, 0, 4'(ENTRIES)));
        add_row(mk_op(rsws_pkg::FUNC_BROADCAST, 32'd10, WAKE_TAG, 32'h8000_0001), 0, none);
        add_row(mk_op(rsws_pkg::FUNC_SELECT, 32'd11, 5'd0, '0), 0, none);
    endfunction

    // Random item with the mix tilted by how full the station is
    function automatic rsws_pkg::t_in_item random_op();
        rsws_pkg::t_in_item         it;
        int                         r;
        int                         disp_pct;
        logic [rsws_pkg::TAG_W-1:0] waiting [$];
        it.func           = rsws_pkg::FUNC_SELECT;
        it.cycle          = cur_cycle;
        it.opcode         = $urandom;
        it.seq_num        = $urandom;
        it.tag_in         = $urandom_range(0, 31);
        it.first_pending  = ($urandom_range(0, 99) < 50);
        it.first_tag      = $urandom_range(0, 31);
        it.first_value    = $urandom;
        it.second_pending = ($urandom_range(0, 99) < 40);
        it.second_tag     = $urandom_range(0, 31);
        it.second_value   = $urandom;
        disp_pct = (held < 3) ? 60 : (held >= ENTRIES - 1) ? 20 : 40;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            it.func = FUNC_UNUSED;
        end else if (r < 4 + disp_pct) begin
            it.func = rsws_pkg::FUNC_DISPATCH;
        end else if (r < 34 + disp_pct) begin
            it.func = rsws_pkg::FUNC_BROADCAST;
            // mostly broadcast a tag that something is waiting on
            for (int i = 0; i < held; i++) begin
                if (slots[i].first_wait) waiting.push_back(slots[i].first_tag);
                if (slots[i].second_wait) waiting.push_back(slots[i].second_tag);
            end
            if (waiting.size() > 0 && $urandom_range(0, 99) < 80)
                it.tag_in = waiting[$urandom_range(0, waiting.size() - 1)];
        end
        return it;
    endfunction

    // Present one item, wait for the handshake, record the predicted outcome
    task automatic send_item(rsws_pkg::t_in_item it, bit typed, rsws_pkg::t_out_item want);
        rsws_pkg::t_out_item got;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        got = station_step(it);
        pending_outcomes.push_back(typed ? want : got);
    endtask

    task automatic run_random(int count);
        logic [rsws_pkg::CYC_W-1:0] step;
        for (int k = 0; k < count; k++) begin
            step = $urandom_range(0, 2);
            cur_cycle = (cur_cycle > '1 - step) ? '1 : cur_cycle + step;
            send_item(random_op(), 1'b0, '0);
        end
    endtask

    // Hold the sender off until every outcome has come back
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    // Result side: compare against the oldest outcome, then pick next ready
    always @(posedge i_clk) begin
        rsws_pkg::t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_outcomes.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("result with nothing outstanding: %p", out_ch.data);
            end else begin
                want = pending_outcomes.pop_front();
                if (out_ch.data.accepted !== want.accepted ||
                    out_ch.data.issued !== want.issued ||
                    out_ch.data.out_opcode !== want.out_opcode ||
                    out_ch.data.out_seq !== want.out_seq ||
                    out_ch.data.out_dest !== want.out_dest ||
                    out_ch.data.out_first !== want.out_first ||
                    out_ch.data.out_second !== want.out_second ||
                    out_ch.data.occupancy !== want.occupancy) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("exp acc=%b iss=%b op=%h seq=%h dst=%0d a=%h b=%h occ=%0d",
                                 want.accepted, want.issued, want.out_opcode, want.out_seq,
                                 want.out_dest, want.out_first, want.out_second,
                                 want.occupancy);
                        $display("act acc=%b iss=%b op=%h seq=%h dst=%0d a=%h b=%h occ=%0d",
                                 out_ch.data.accepted, out_ch.data.issued,
                                 out_ch.data.out_opcode, out_ch.data.out_seq,
                                 out_ch.data.out_dest, out_ch.data.out_first,
                                 out_ch.data.out_second, out_ch.data.occupancy);
                    end
                end
            end
        end
        out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // Watchdog: too long without any item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("reservation_station_wakeup_select_unit_test: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence
    initial begin
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        i_rst_n      <= 1'b0;
        held         = 0;
        cur_cycle    = '0;
        src_idle_pct = 6;
        snk_idle_pct = 71;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        build_rows();
        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        cur_cycle = 32'd12;
        run_random(250);
        drain();

        src_idle_pct = 71;
        snk_idle_pct = 6;
        run_random(250);
        drain();

        // last phase runs the cycle count near its top value, where it saturates
        src_idle_pct = 0;
        snk_idle_pct = 0;
        cur_cycle = 32'hFFFF_FF00;
        run_random(250);
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_outcomes.size() == 0)
            $display("reservation_station_wakeup_select_unit_test: PASS");
        else
            $display("reservation_station_wakeup_select_unit_test: FAIL");
        $finish;
    end

endmodule
